@@ rtl/pinhole_point_projection_unit_assert.svh @@
// Assertion macros for the pinhole point projection unit.
// Depends on nothing; included by the top level.
`ifndef PINHOLE_POINT_PROJECTION_UNIT_ASSERT_SVH
`define PINHOLE_POINT_PROJECTION_UNIT_ASSERT_SVH

// Same-cycle implication
`define PPP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define PPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/ppp_pkg.sv @@
// Shared types and constants of the pinhole point projection unit.
// Depends on nothing.
`default_nettype none
package ppp_pkg;
   localparam int COORD_W = 16;
   localparam int ROT_W   = 16;
   localparam int ROT_FRAC = 14;
   localparam int CSR_W   = 48;
   localparam int INTR_W  = 12;
   localparam int CAM_W   = 34;   // camera-frame coordinate
   localparam int PROD_W  = 47;   // intrinsic product
   localparam int NUM_W   = 48;   // signed numerator
   localparam int DIV_W   = 52;   // divider working width
   localparam int QBITS   = 17;   // quotient bits below the overflow test
   localparam int IDX_W   = 4;

   typedef enum logic [IDX_W-1:0] {
      REG_ROT_ROW0    = 4'd0,
      REG_ROT_ROW1    = 4'd1,
      REG_ROT_ROW2    = 4'd2,
      REG_TRANSLATION = 4'd3,
      REG_FOCAL_X     = 4'd4,
      REG_FOCAL_Y     = 4'd5,
      REG_CENTER_X    = 4'd6,
      REG_CENTER_Y    = 4'd7
   } reg_idx_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic behind;
   } meta_type;

   typedef struct packed {
      logic [CSR_W-1:0]  rot_row0;
      logic [CSR_W-1:0]  rot_row1;
      logic [CSR_W-1:0]  rot_row2;
      logic [CSR_W-1:0]  translation;
      logic [INTR_W-1:0] focal_x;
      logic [INTR_W-1:0] focal_y;
      logic [INTR_W-1:0] center_x;
      logic [INTR_W-1:0] center_y;
   } cam_cfg_type;
endpackage
`default_nettype wire

@@ rtl/ppp_camera_xform.sv @@
// Rotation, translation and intrinsics: four stages from world point to
// divider operands. Depends on ppp_pkg.
`default_nettype none
module ppp_camera_xform import ppp_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire logic signed [COORD_W-1:0] world_x,
   input  wire logic signed [COORD_W-1:0] world_y,
   input  wire logic signed [COORD_W-1:0] world_z,
   input  wire cam_cfg_type               cfg,
   output meta_type                       meta_out,
   output logic [DIV_W-1:0]               num_out,
   output logic [DIV_W-1:0]               den_out
);
   // stage 1: rotation products, row 0 in slots 0..2, row 2 in slots 3..5
   logic signed [2*COORD_W-1:0] prod_ff [6];
   logic signed [2*COORD_W-1:0] prod_in [6];
   logic v1_ff;
   // stage 2: camera coordinates
   logic signed [CAM_W-1:0] cx_ff, cz_ff, cx_in, cz_in;
   logic v2_ff;
   // stage 3: intrinsic products
   logic signed [PROD_W-1:0] fu_ff, cu_ff, fu_in, cu_in;
   logic signed [CAM_W-1:0]  cz3_ff;
   logic v3_ff, behind3_ff;
   // stage 4: numerator magnitude and divisor
   logic signed [NUM_W-1:0] num_s;
   logic [NUM_W-1:0]        mag;
   logic [DIV_W-1:0]        num_ff, den_ff, num_in, den_in;
   meta_type                meta_ff, meta_in;

   function automatic logic signed [ROT_W-1:0] lane(input logic [CSR_W-1:0] p,
                                                    input int k);
      return p[16*k +: 16];
   endfunction

   always_comb begin
      prod_in[0] = lane(cfg.rot_row0, 0) * world_x;
      prod_in[1] = lane(cfg.rot_row0, 1) * world_y;
      prod_in[2] = lane(cfg.rot_row0, 2) * world_z;
      prod_in[3] = lane(cfg.rot_row2, 0) * world_x;
      prod_in[4] = lane(cfg.rot_row2, 1) * world_y;
      prod_in[5] = lane(cfg.rot_row2, 2) * world_z;
   end

   always_comb begin
      cx_in = CAM_W'(prod_ff[0]) + CAM_W'(prod_ff[1]) + CAM_W'(prod_ff[2])
            + (CAM_W'(lane(cfg.translation, 0)) <<< ROT_FRAC);
      cz_in = CAM_W'(prod_ff[3]) + CAM_W'(prod_ff[4]) + CAM_W'(prod_ff[5])
            + (CAM_W'(lane(cfg.translation, 2)) <<< ROT_FRAC);
   end

   // u and v do not share the pipeline: x goes on lane u, y is handled by a twin
   // instance; here this module is instantiated once per axis
   always_comb begin
      fu_in = PROD_W'($signed({1'b0, cfg.focal_x})) * PROD_W'(cx_ff);
      cu_in = PROD_W'($signed({1'b0, cfg.center_x})) * PROD_W'(cz_ff);
   end

   always_comb begin
      num_s  = NUM_W'(fu_ff) + NUM_W'(cu_ff);
      mag    = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
      num_in = {mag, 1'b0} + DIV_W'(unsigned'(cz3_ff));
      den_in = DIV_W'({cz3_ff, 1'b0});
      meta_in = '{valid: v3_ff, neg: num_s[NUM_W-1], behind: behind3_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         meta_ff <= '0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         meta_ff <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         cx_ff <= cx_in;
         cz_ff <= cz_in;
         fu_ff <= fu_in;
         cu_ff <= cu_in;
         cz3_ff <= cz_ff;
         behind3_ff <= (cz_ff <= 0);
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign meta_out = meta_ff;
   assign num_out  = num_ff;
   assign den_out  = den_ff;
endmodule
`default_nettype wire

@@ rtl/ppp_round_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sign and
// 16-bit saturation in the last stage; rounding comes from the operands. Depends on ppp_pkg.
`default_nettype none
module ppp_round_div import ppp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire meta_type          meta_in,
   input  wire logic [DIV_W-1:0]  num_in,
   input  wire logic [DIV_W-1:0]  den_in,
   output logic                   out_valid,
   output logic                   out_behind,
   output logic signed [COORD_W-1:0] out_pixel
);
   logic [DIV_W-1:0] rem_ff [QBITS+1];
   logic [DIV_W-1:0] den_ff [QBITS+1];
   logic [QBITS-1:0] quo_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];
   meta_type         meta_ff [QBITS+1];
   logic             valid_ff, behind_ff;
   logic signed [COORD_W-1:0] pixel_ff, pixel_in;

   // stage 0: quotient would not fit in QBITS bits
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff[0] <= '0;
      end else if (advance) begin
         meta_ff[0] <= meta_in;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= num_in;
         den_ff[0] <= den_in;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (num_in >= (den_in << QBITS));
      end
   end

   // one stage per quotient bit, MSB first
   for (genvar k = 0; k < QBITS; k++) begin : g_bit
      logic [DIV_W-1:0] shifted;
      logic             take;
      logic [QBITS-1:0] quo_in;
      always_comb begin
         shifted = den_ff[k] << (QBITS - 1 - k);
         take    = (rem_ff[k] >= shifted);
         quo_in  = quo_ff[k];
         quo_in[QBITS-1-k] = take;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[k+1] <= '0;
         end else if (advance) begin
            meta_ff[k+1] <= meta_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1] <= take ? rem_ff[k] - shifted : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
            quo_ff[k+1] <= quo_in;
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   // sign, saturation and the behind-camera override
   always_comb begin
      if (meta_ff[QBITS].behind) begin
         pixel_in = '0;
      end else if (meta_ff[QBITS].neg) begin
         if (ovf_ff[QBITS] || quo_ff[QBITS] > QBITS'(32768))
            pixel_in = 16'sh8000;
         else
            pixel_in = COORD_W'(~quo_ff[QBITS] + 1'b1);
      end else begin
         if (ovf_ff[QBITS] || quo_ff[QBITS] > QBITS'(32767))
            pixel_in = 16'sh7fff;
         else
            pixel_in = COORD_W'(quo_ff[QBITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= meta_ff[QBITS].valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff  <= pixel_in;
         behind_ff <= meta_ff[QBITS].behind;
      end
   end

   assign out_valid  = valid_ff;
   assign out_behind = behind_ff;
   assign out_pixel  = pixel_ff;
endmodule
`default_nettype wire

@@ rtl/pinhole_point_projection_unit.sv @@
// Pipeline: 4 transform stages including the input product stage, 18 divider
// stages and 1 output stage lie between an accepted req beat and its rsp beat.
// Throughput: one point per cycle; the whole pipeline freezes while a rsp
// beat is stalled. Synchronous active-high reset empties the pipeline and
// loads the default camera registers.
`default_nettype none
`include "pinhole_point_projection_unit_assert.svh"
module pinhole_point_projection_unit import ppp_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [COORD_W-1:0] req_world_x,
   input  wire logic signed [COORD_W-1:0] req_world_y,
   input  wire logic signed [COORD_W-1:0] req_world_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [COORD_W-1:0]      rsp_pixel_u,
   output logic signed [COORD_W-1:0]      rsp_pixel_v,
   output logic                           rsp_behind_camera,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [IDX_W-1:0]          csr_index,
   input  wire logic [CSR_W-1:0]          csr_wdata
);
   cam_cfg_type cfg_ff, cfg_u, cfg_v;
   logic        advance;
   meta_type    meta_u, meta_v;
   logic [DIV_W-1:0] num_u, den_u, num_v, den_v;
   logic        valid_v, behind_v;

   // pipeline moves unless a finished beat waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_row0    <= 48'd211106232532992;
         cfg_ff.rot_row1    <= 48'd49152;
         cfg_ff.rot_row2    <= 48'd1073741824;
         cfg_ff.translation <= 48'd2199056810496;
         cfg_ff.focal_x     <= 12'd400;
         cfg_ff.focal_y     <= 12'd400;
         cfg_ff.center_x    <= 12'd190;
         cfg_ff.center_y    <= 12'd160;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROT_ROW0:    cfg_ff.rot_row0    <= csr_wdata;
            REG_ROT_ROW1:    cfg_ff.rot_row1    <= csr_wdata;
            REG_ROT_ROW2:    cfg_ff.rot_row2    <= csr_wdata;
            REG_TRANSLATION: cfg_ff.translation <= csr_wdata;
            REG_FOCAL_X:     cfg_ff.focal_x     <= csr_wdata[INTR_W-1:0];
            REG_FOCAL_Y:     cfg_ff.focal_y     <= csr_wdata[INTR_W-1:0];
            REG_CENTER_X:    cfg_ff.center_x    <= csr_wdata[INTR_W-1:0];
            REG_CENTER_Y:    cfg_ff.center_y    <= csr_wdata[INTR_W-1:0];
            default: ;
         endcase
      end
   end

   // u lane uses row 0 and x intrinsics; v lane sees row 1 in the row-0 slot
   always_comb begin
      cfg_u = cfg_ff;
      cfg_v = cfg_ff;
      cfg_v.rot_row0 = cfg_ff.rot_row1;
      cfg_v.translation = {cfg_ff.translation[47:32], cfg_ff.translation[31:16],
                           cfg_ff.translation[31:16]};
      cfg_v.focal_x  = cfg_ff.focal_y;
      cfg_v.center_x = cfg_ff.center_y;
   end

   ppp_camera_xform u_xform_u (
      .clock, .reset, .advance, .in_valid(req_valid),
      .world_x(req_world_x), .world_y(req_world_y), .world_z(req_world_z),
      .cfg(cfg_u), .meta_out(meta_u), .num_out(num_u), .den_out(den_u));

   ppp_camera_xform u_xform_v (
      .clock, .reset, .advance, .in_valid(req_valid),
      .world_x(req_world_x), .world_y(req_world_y), .world_z(req_world_z),
      .cfg(cfg_v), .meta_out(meta_v), .num_out(num_v), .den_out(den_v));

   ppp_round_div u_div_u (
      .clock, .reset, .advance, .meta_in(meta_u), .num_in(num_u), .den_in(den_u),
      .out_valid(rsp_valid), .out_behind(rsp_behind_camera), .out_pixel(rsp_pixel_u));

   ppp_round_div u_div_v (
      .clock, .reset, .advance, .meta_in(meta_v), .num_in(num_v), .den_in(den_v),
      .out_valid(valid_v), .out_behind(behind_v), .out_pixel(rsp_pixel_v));

   `PPP_ASSERT_NOW(a_behind_zero, clock, reset, rsp_valid && rsp_behind_camera,
      rsp_pixel_u == 16'sd0 && rsp_pixel_v == 16'sd0)
   `PPP_ASSERT_NOW(a_lanes_agree, clock, reset, 1'b1,
      rsp_valid == valid_v && (!rsp_valid || rsp_behind_camera == behind_v))
   `PPP_ASSERT_NEXT(a_hold_result, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pixel_u) && $stable(rsp_pixel_v))
endmodule
`default_nettype wire

@@ bench/tb_pinhole_point_projection_unit.sv @@
// Testbench for the pinhole point projection unit: random and directed points
// through several camera settings, checked against a built-in projection predictor.
// Depends on ppp_pkg and the pinhole_point_projection_unit RTL.
`default_nettype none
module tb_pinhole_point_projection_unit import ppp_pkg::*; ;

   typedef struct {
      logic signed [15:0] u;
      logic signed [15:0] v;
      logic               behind;
   } pixel_type;

   // Projection scoreboard: camera copy plus queue of expected pixels
   class projection_board_type;
      logic [47:0] rot [3];
      logic [47:0] trans;
      logic [11:0] fx, fy, cx, cy;
      pixel_type   pending [$];
      int          errors;

      function void load_defaults();
         rot[0] = 48'd211106232532992;
         rot[1] = 48'd49152;
         rot[2] = 48'd1073741824;
         trans  = 48'd2199056810496;
         fx = 12'd400; fy = 12'd400; cx = 12'd190; cy = 12'd160;
      endfunction

      function void write_reg(reg_idx_type idx, logic [47:0] val);
         case (idx)
            REG_ROT_ROW0: rot[0] = val;
            REG_ROT_ROW1: rot[1] = val;
            REG_ROT_ROW2: rot[2] = val;
            REG_TRANSLATION: trans = val;
            REG_FOCAL_X: fx = val[11:0];
            REG_FOCAL_Y: fy = val[11:0];
            REG_CENTER_X: cx = val[11:0];
            REG_CENTER_Y: cy = val[11:0];
            default: ;
         endcase
      endfunction

      function longint lane16(logic [47:0] p, int k);
         logic signed [15:0] s;
         s = p[16*k +: 16];
         return longint'(s);
      endfunction

      // rounded quotient, ties away from zero, saturated to 16 bits
      function logic [15:0] div_round(longint num, longint den);
         longint mag, q;
         mag = (num < 0) ? -num : num;
         q = (2 * mag + den) / (2 * den);
         if (num < 0) return (q > 32768) ? 16'h8000 : 16'(-q);
         return (q > 32767) ? 16'h7fff : 16'(q);
      endfunction

      function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
         longint c [3];
         pixel_type p;
         for (int r = 0; r < 3; r++)
            c[r] = lane16(rot[r], 0) * x + lane16(rot[r], 1) * y
                 + lane16(rot[r], 2) * z + lane16(trans, r) * 16384;
         if (c[2] <= 0) begin
            p.u = 0; p.v = 0; p.behind = 1'b1;
         end else begin
            p.u = div_round(longint'(fx) * c[0] + longint'(cx) * c[2], c[2]);
            p.v = div_round(longint'(fy) * c[1] + longint'(cy) * c[2], c[2]);
            p.behind = 1'b0;
         end
         pending.push_back(p);
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_pixel(logic signed [15:0] u, logic signed [15:0] v, logic b);
         pixel_type e;
         if (pending.size() == 0) begin
            report_mismatch("rsp beat with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (u !== e.u) report_mismatch($sformatf("pixel_u %0d exp %0d", u, e.u));
         if (v !== e.v) report_mismatch($sformatf("pixel_v %0d exp %0d", v, e.v));
         if (b !== e.behind)
            report_mismatch($sformatf("behind_camera %0b exp %0b", b, e.behind));
      endtask
   endclass

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, rsp_stall = 1'b0, csr_valid = 1'b0;
   logic signed [15:0] req_world_x = '0, req_world_y = '0, req_world_z = '0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   wire req_stall, rsp_valid, rsp_behind_camera, csr_ready;
   wire signed [15:0] rsp_pixel_u, rsp_pixel_v;

   projection_board_type board = new();
   int  cycles = 0;
   int  idle_pct = 25;
   localparam int CYCLE_LIMIT = 200000;

   pinhole_point_projection_unit u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: random stall, check each accepted beat
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall)
         board.check_pixel(rsp_pixel_u, rsp_pixel_v, rsp_behind_camera);
      rsp_stall <= ($urandom_range(99) < idle_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL pinhole_point_projection_unit");
         $finish;
      end
   end

   // One write beat, then csr_valid drops before the next write
   task write_csr(reg_idx_type idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One point beat; valid stays high between back-to-back beats
   task send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_world_x <= x;
      req_world_y <= y;
      req_world_z <= z;
      do @(posedge clock); while (req_stall);
      board.note_point(x, y, z);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [15:0] rot_entry();
      case ($urandom_range(5))
         0: return 16'h4000;
         1: return 16'hc000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] coord();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(2047)) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   task random_points(int n);
      for (int i = 0; i < n; i++) send_point(coord(), coord(), coord());
   endtask

   logic [15:0] edges [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

   initial begin
      board.load_defaults();
      board.errors = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default camera, field extremes and a point behind the camera
      for (int i = 0; i < 4; i++) send_point(edges[i], edges[(i+1)%4], edges[(i+2)%4]);
      send_point(16'h0100, 16'h0100, 16'hfe00);   // in front of the camera; depth follows y
      send_point(16'h0100, 16'h0000, 16'hf000);   // in front of the camera
      send_point(16'h0000, 16'h0001, 16'h0000);
      send_point(16'h0000, 16'h0000, 16'h7fff);   // in range, no saturation
      send_point(16'h7fff, 16'h7fff, 16'h7fff);
      drain();

      // Identity camera, tiny focal: exact halves and extremes of intrinsics
      write_csr(REG_ROT_ROW0, 48'h0000_0000_4000);
      write_csr(REG_ROT_ROW1, 48'h0000_4000_0000);
      write_csr(REG_ROT_ROW2, 48'h4000_0000_0000);
      write_csr(REG_TRANSLATION, 48'h0000_0000_0000);
      write_csr(REG_FOCAL_X, 48'd1);
      write_csr(REG_FOCAL_Y, 48'hfff);
      write_csr(REG_CENTER_X, 48'd0);
      write_csr(REG_CENTER_Y, 48'hfff);
      send_point(16'h0080, 16'hff80, 16'h0100);    // halves, both signs
      send_point(16'h0180, 16'hfe80, 16'h0100);
      send_point(16'h7fff, 16'h8000, 16'h0001);
      send_point(16'h8000, 16'h7fff, 16'h0001);
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h0100, 16'h0100, 16'h8000);
      drain();

      // Random camera phases, one long stretch without idling
      for (int ph = 0; ph < 6; ph++) begin
         idle_pct = (ph == 2) ? 0 : 25;
         for (int r = 0; r < 3; r++)
            write_csr(reg_idx_type'(r), {rot_entry(), rot_entry(), rot_entry()});
         write_csr(REG_TRANSLATION, (ph == 5) ? 48'hffff_ffff_ffff
                                              : {coord(), coord(), coord()});
         write_csr(REG_FOCAL_X, (ph == 5) ? 48'hfff : 48'($urandom));
         write_csr(REG_FOCAL_Y, (ph == 4) ? 48'd0 : 48'($urandom));
         write_csr(REG_CENTER_X, 48'($urandom));
         write_csr(REG_CENTER_Y, (ph == 4) ? 48'd0 : 48'($urandom));
         random_points(120);
         drain();
      end
      idle_pct = 25;

      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS pinhole_point_projection_unit");
      else
         $display("FAIL pinhole_point_projection_unit");
      $finish;
   end
endmodule
`default_nettype wire
